/* rtl/core/status_led_breathing_fader_assert.svh */
// Assertion macros used by the status LED fader checker.
// Each macro expands to one labeled concurrent assertion with reset disable.
`ifndef STATUS_LED_BREATHING_FADER_ASSERT_SVH
`define STATUS_LED_BREATHING_FADER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define SLF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SLF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/slf_pkg.sv */
// Shared types, constants and helpers for the status LED breathing fader.
// No dependencies; every other file in rtl/core but the assertion header refers to it by scoped names.
package slf_pkg;

    // Width of the wrapping time base the fade timer works in.
    localparam int TIME_BITS  = 32;
    localparam int NOW_W      = 32;
    localparam int STAMP_W    = (TIME_BITS < NOW_W) ? TIME_BITS : NOW_W;
    // With a time base wider than the input stamp a negative difference never wraps small.
    localparam bit TIME_WIDE  = (TIME_BITS > NOW_W);

    localparam int MODE_W     = 3;
    localparam int PREV_W     = MODE_W + 1;
    localparam int LEVEL_W    = 8;
    localparam int INTERVAL_W = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_STEP_INTERVAL = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_NORMAL_STEP   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FAST_STEP     = 2'd2;

    localparam logic [INTERVAL_W-1:0] RST_STEP_INTERVAL = 16'd10;
    localparam logic [LEVEL_W-1:0]    RST_NORMAL_STEP   = 8'd5;
    localparam logic [LEVEL_W-1:0]    RST_FAST_STEP     = 8'd15;

    localparam logic [LEVEL_W-1:0] LEVEL_MIN = 8'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;
    // Previous-mode code that no input mode can match.
    localparam logic [PREV_W-1:0]  NO_MODE   = 4'd8;

    typedef enum logic [MODE_W-1:0] {
        MODE_SYNC       = 3'd0,
        MODE_AP         = 3'd1,
        MODE_CONNECTING = 3'd2,
        MODE_CONNECTED  = 3'd3,
        MODE_ERROR      = 3'd4,
        MODE_CHECK      = 3'd5,
        MODE_UPDATE     = 3'd6,
        MODE_OFF        = 3'd7
    } t_mode;

    typedef struct packed {
        logic [INTERVAL_W-1:0] step_interval_ms;
        logic [LEVEL_W-1:0]    normal_step;
        logic [LEVEL_W-1:0]    fast_step;
    } t_cfg;

    function automatic logic is_fading(input t_mode mode);
        logic fade;
        fade = (mode == MODE_SYNC) || (mode == MODE_CONNECTING) || (mode == MODE_ERROR) ||
               (mode == MODE_CHECK) || (mode == MODE_UPDATE);
        return fade;
    endfunction

endpackage

/* rtl/core/slf_if.sv */
// Valid/ready channel interfaces of the status LED breathing fader.
// Depends on slf_pkg for field widths.
interface slf_item_if;
    logic                         valid;
    logic                         ready;
    logic [slf_pkg::MODE_W-1:0]   mode;
    logic [slf_pkg::NOW_W-1:0]    now_ms;
    logic                         safe_mode;

    modport source (output valid, output mode, output now_ms, output safe_mode, input ready);
    modport sink   (input valid, input mode, input now_ms, input safe_mode, output ready);
endinterface

interface slf_rgb_if;
    logic                         valid;
    logic                         ready;
    logic [slf_pkg::LEVEL_W-1:0]  red;
    logic [slf_pkg::LEVEL_W-1:0]  green;
    logic [slf_pkg::LEVEL_W-1:0]  blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface slf_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [slf_pkg::CFG_ADDR_W-1:0] addr;
    logic [slf_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

/* rtl/core/slf_cfg_regs.sv */
// Configuration register file: step interval, normal step and fast step.
// Depends on slf_pkg and slf_cfg_if.
module slf_cfg_regs (
    input  logic             i_clk,
    input  logic             i_rst_n,
    slf_cfg_if.sink          i_cfg,
    output slf_pkg::t_cfg    o_cfg
);

    slf_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_interval_ms <= slf_pkg::RST_STEP_INTERVAL;
            r_cfg.normal_step      <= slf_pkg::RST_NORMAL_STEP;
            r_cfg.fast_step        <= slf_pkg::RST_FAST_STEP;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.addr)
                slf_pkg::REG_STEP_INTERVAL: begin
                    r_cfg.step_interval_ms <= i_cfg.data[slf_pkg::INTERVAL_W-1:0];
                end
                slf_pkg::REG_NORMAL_STEP: begin
                    r_cfg.normal_step <= i_cfg.data[slf_pkg::LEVEL_W-1:0];
                end
                slf_pkg::REG_FAST_STEP: begin
                    r_cfg.fast_step <= i_cfg.data[slf_pkg::LEVEL_W-1:0];
                end
                default: begin
                    // unmapped index: drop the write
                end
            endcase
        end
    end

endmodule

/* rtl/core/slf_fade_core.sv */
// Fade state (level, direction, step time, last mode) and the colour decode.
// Computes the next state and RGB triple of one item combinationally. Depends on slf_pkg.
module slf_fade_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_commit,
    input  logic [slf_pkg::MODE_W-1:0]    i_mode,
    input  logic [slf_pkg::STAMP_W-1:0]   i_now,
    input  slf_pkg::t_cfg                 i_cfg,
    output logic [slf_pkg::LEVEL_W-1:0]   o_red,
    output logic [slf_pkg::LEVEL_W-1:0]   o_green,
    output logic [slf_pkg::LEVEL_W-1:0]   o_blue
);

    logic [slf_pkg::LEVEL_W-1:0] r_level;
    logic                        r_rising;
    logic [slf_pkg::STAMP_W-1:0] r_last;
    logic [slf_pkg::PREV_W-1:0]  r_prev_mode;

    logic [slf_pkg::LEVEL_W-1:0] n_level;
    logic                        n_rising;
    logic [slf_pkg::STAMP_W-1:0] n_last;

    slf_pkg::t_mode              mode;
    logic                        mode_change;
    logic [slf_pkg::LEVEL_W-1:0] base_level;
    logic                        base_rising;
    logic [slf_pkg::STAMP_W-1:0] base_last;
    logic [slf_pkg::STAMP_W:0]   diff;
    logic                        elapsed_ok;
    logic                        step_en;
    logic [slf_pkg::LEVEL_W-1:0] step;
    logic [slf_pkg::LEVEL_W:0]   rise_sum;

    always_comb begin
        mode        = slf_pkg::t_mode'(i_mode);
        mode_change = (r_prev_mode != {1'b0, i_mode});
        // A new mode restarts the fade from zero, rising, timed from now.
        base_level  = mode_change ? slf_pkg::LEVEL_MIN : r_level;
        base_rising = mode_change ? 1'b1 : r_rising;
        base_last   = mode_change ? i_now : r_last;

        diff       = {1'b0, i_now} - {1'b0, base_last};
        elapsed_ok = (slf_pkg::TIME_WIDE && diff[slf_pkg::STAMP_W]) ||
                     (diff[slf_pkg::STAMP_W-1:0] >=
                      slf_pkg::STAMP_W'(i_cfg.step_interval_ms));
        step_en    = slf_pkg::is_fading(mode) && elapsed_ok;
        step       = (mode == slf_pkg::MODE_SYNC) ? i_cfg.fast_step : i_cfg.normal_step;
        rise_sum   = {1'b0, base_level} + {1'b0, step};

        n_level  = base_level;
        n_rising = base_rising;
        n_last   = base_last;
        if (step_en) begin
            n_last = i_now;
            // Clamp at either end and reverse.
            if (base_rising) begin
                if (rise_sum >= {1'b0, slf_pkg::LEVEL_MAX}) begin
                    n_level  = slf_pkg::LEVEL_MAX;
                    n_rising = 1'b0;
                end else begin
                    n_level = rise_sum[slf_pkg::LEVEL_W-1:0];
                end
            end else begin
                if (base_level <= step) begin
                    n_level  = slf_pkg::LEVEL_MIN;
                    n_rising = 1'b1;
                end else begin
                    n_level = base_level - step;
                end
            end
        end

        o_red   = '0;
        o_green = '0;
        o_blue  = '0;
        unique case (mode)
            slf_pkg::MODE_SYNC:       o_green = n_level;
            slf_pkg::MODE_AP: begin
                o_red   = slf_pkg::LEVEL_MAX;
                o_green = slf_pkg::LEVEL_MAX;
            end
            slf_pkg::MODE_CONNECTING: o_blue  = n_level;
            slf_pkg::MODE_CONNECTED:  o_green = slf_pkg::LEVEL_MAX;
            slf_pkg::MODE_ERROR:      o_red   = n_level;
            slf_pkg::MODE_CHECK: begin
                o_red  = n_level;
                o_blue = n_level;
            end
            slf_pkg::MODE_UPDATE: begin
                o_red   = n_level;
                o_green = n_level;
                o_blue  = n_level;
            end
            slf_pkg::MODE_OFF: begin
                // stays dark
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= slf_pkg::LEVEL_MIN;
            r_rising    <= 1'b1;
            r_last      <= '0;
            r_prev_mode <= slf_pkg::NO_MODE;
        end else if (i_commit) begin
            r_level     <= n_level;
            r_rising    <= n_rising;
            r_last      <= n_last;
            r_prev_mode <= {1'b0, i_mode};
        end
    end

endmodule

/* rtl/core/status_led_breathing_fader.sv */
// Top level of the status LED breathing fader: input register, fade core, result register.
// Depends on slf_pkg, slf_if.sv, slf_cfg_regs and slf_fade_core.
//
// Usage:
//   i_item carries one transaction per cycle while i_item.ready is high: mode, now_ms and safe_mode.
//   o_result returns the red/green/blue duty triple of each item that is
//   not in safe mode; safe-mode items are consumed with no result and no
//   change to the fade state.
//   i_cfg writes step_interval_ms (index 0), normal_step (1), fast_step (2);
//   it is always ready and other indexes are ignored. Write it only while idle.
// Path: an accepted item waits in the input register; its result loads into the
//   result register through the fade core once that register is free.
// Throughput: one item per cycle while results are taken; the fade update (time
//   compare, step add and clamp) is combinational between input and result registers.
// Reset: fade level 0, rising, last step time 0, no mode seen, registers at
//   10 / 5 / 15; both pipeline registers empty.
// Stall: while o_result is held, the input register still accepts one more
//   item; once it holds an item that has a result, i_item.ready drops until
//   the result is taken.
module status_led_breathing_fader (
    input  logic        i_clk,
    input  logic        i_rst_n,
    slf_item_if.sink    i_item,
    slf_cfg_if.sink     i_cfg,
    slf_rgb_if.source   o_result
);

    logic                          r_in_valid;
    logic [slf_pkg::MODE_W-1:0]    r_mode;
    logic [slf_pkg::STAMP_W-1:0]   r_now;
    logic                          r_safe;

    logic                          r_out_valid;
    logic [slf_pkg::LEVEL_W-1:0]   r_red;
    logic [slf_pkg::LEVEL_W-1:0]   r_green;
    logic [slf_pkg::LEVEL_W-1:0]   r_blue;

    slf_pkg::t_cfg                 cfg;
    logic                          out_free;
    logic                          advance;
    logic                          commit;
    logic [slf_pkg::LEVEL_W-1:0]   core_red;
    logic [slf_pkg::LEVEL_W-1:0]   core_green;
    logic [slf_pkg::LEVEL_W-1:0]   core_blue;

    assign out_free     = !r_out_valid || o_result.ready;
    // Safe-mode items leave without needing the result register.
    assign advance      = r_in_valid && (r_safe || out_free);
    assign commit       = advance && !r_safe;
    assign i_item.ready = !r_in_valid || advance;

    assign o_result.valid = r_out_valid;
    assign o_result.red   = r_red;
    assign o_result.green = r_green;
    assign o_result.blue  = r_blue;

    slf_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    slf_fade_core u_fade_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_commit (commit),
        .i_mode   (r_mode),
        .i_now    (r_now),
        .i_cfg    (cfg),
        .o_red    (core_red),
        .o_green  (core_green),
        .o_blue   (core_blue)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_mode <= i_item.mode;
            r_now  <= i_item.now_ms[slf_pkg::STAMP_W-1:0];
            r_safe <= i_item.safe_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_red   <= core_red;
            r_green <= core_green;
            r_blue  <= core_blue;
        end
    end

endmodule

/* rtl/core/slf_checker.sv */
// Port-level checker for the status LED breathing fader, bound to the top level.
// Depends on status_led_breathing_fader_assert.svh and slf_pkg.
`include "status_led_breathing_fader_assert.svh"

module slf_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_cfg_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [slf_pkg::LEVEL_W-1:0]  i_red,
    input logic [slf_pkg::LEVEL_W-1:0]  i_green,
    input logic [slf_pkg::LEVEL_W-1:0]  i_blue
);

    // A held result keeps its colour until taken.
    `SLF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_red) && $stable(i_green) && $stable(i_blue), "result changed while stalled")

    // A fresh result comes from a transaction accepted earlier on the input channel.
    `SLF_ASSERT_SAME(a_out_source, i_clk, i_rst_n, $rose(i_out_valid), $past(i_in_valid && i_in_ready, 2), "result without a matching input transaction")

    // Every colour the decoder makes has all lit channels at one value.
    `SLF_ASSERT_SAME(a_colour_shape, i_clk, i_rst_n, i_out_valid, (i_red == '0 || i_green == '0 || i_red == i_green) && (i_red == '0 || i_blue == '0 || i_red == i_blue) && (i_green == '0 || i_blue == '0 || i_green == i_blue), "impossible colour combination")

    // Register writes are never back-pressured.
    `SLF_ASSERT_SAME(a_cfg_ready, i_clk, i_rst_n, 1'b1, i_cfg_ready, "configuration port not ready")

endmodule

bind status_led_breathing_fader slf_checker u_slf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_cfg_ready (i_cfg.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_red       (o_result.red),
    .i_green     (o_result.green),
    .i_blue      (o_result.blue)
);

/* tb/status_led_breathing_fader_test.sv */
// Self-checking testbench for the status LED breathing fader: drives mode/time items and
// register writes, predicts every RGB result and compares it. Needs slf_pkg and slf_if.sv.
module status_led_breathing_fader_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Index that no register decodes; writes to it must change nothing.
    localparam logic [slf_pkg::CFG_ADDR_W-1:0] REG_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 6;
    localparam int IDLE_LIMIT    = 2000;
    localparam int RUN_ITEMS     = 76;

    typedef struct packed {
        logic [slf_pkg::LEVEL_W-1:0] red;
        logic [slf_pkg::LEVEL_W-1:0] green;
        logic [slf_pkg::LEVEL_W-1:0] blue;
    } t_rgb;

    logic i_clk;
    logic i_rst_n;

    slf_item_if item_ch ();
    slf_cfg_if  cfg_ch ();
    slf_rgb_if  rgb_ch ();

    status_led_breathing_fader u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .i_cfg    (cfg_ch),
        .o_result (rgb_ch)
    );

    // Predicted registers and fade state.
    logic [slf_pkg::INTERVAL_W-1:0] cfg_interval;
    logic [slf_pkg::LEVEL_W-1:0]    cfg_normal;
    logic [slf_pkg::LEVEL_W-1:0]    cfg_fast;
    logic [slf_pkg::LEVEL_W-1:0]    fade_lvl;
    logic                           fade_up;
    logic [slf_pkg::NOW_W-1:0]      last_step_ms;
    logic [slf_pkg::PREV_W-1:0]     last_mode;

    t_rgb pending_rgb[$];
    int   errors       = 0;
    int   items_sent   = 0;
    int   safe_sent    = 0;
    int   rgb_checked  = 0;
    int   reg_writes   = 0;
    int   stall_left   = 0;
    int   idle_cycles  = 0;
    bit   calm         = 1'b0;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic void step_fade(input logic [slf_pkg::LEVEL_W-1:0] inc);
        logic [slf_pkg::LEVEL_W:0] sum;
        sum = {1'b0, fade_lvl} + {1'b0, inc};
        if (fade_up) begin
            if (sum >= {1'b0, slf_pkg::LEVEL_MAX}) begin
                fade_lvl = slf_pkg::LEVEL_MAX;
                fade_up  = 1'b0;
            end else begin
                fade_lvl = sum[slf_pkg::LEVEL_W-1:0];
            end
        end else if (fade_lvl <= inc) begin
            fade_lvl = slf_pkg::LEVEL_MIN;
            fade_up  = 1'b1;
        end else begin
            fade_lvl = fade_lvl - inc;
        end
    endfunction

    function automatic void predict_rgb(input slf_pkg::t_mode mode,
                                        input logic [slf_pkg::NOW_W-1:0] now,
                                        input logic safe);
        t_rgb                      want;
        logic [slf_pkg::NOW_W-1:0] elapsed;
        logic                      fading;
        if (safe) return;
        if ({1'b0, mode} != last_mode) begin
            fade_lvl     = slf_pkg::LEVEL_MIN;
            fade_up      = 1'b1;
            last_step_ms = now;
            last_mode    = {1'b0, mode};
        end
        case (mode)
            slf_pkg::MODE_SYNC, slf_pkg::MODE_CONNECTING, slf_pkg::MODE_ERROR,
            slf_pkg::MODE_CHECK, slf_pkg::MODE_UPDATE: fading = 1'b1;
            default: fading = 1'b0;
        endcase
        // Elapsed time wraps with the counter.
        elapsed = now - last_step_ms;
        if (fading && elapsed >= slf_pkg::NOW_W'(cfg_interval)) begin
            last_step_ms = now;
            step_fade(mode == slf_pkg::MODE_SYNC ? cfg_fast : cfg_normal);
        end
        want = '0;
        case (mode)
            slf_pkg::MODE_SYNC:       want.green = fade_lvl;
            slf_pkg::MODE_AP:         begin
                want.red   = slf_pkg::LEVEL_MAX;
                want.green = slf_pkg::LEVEL_MAX;
            end
            slf_pkg::MODE_CONNECTING: want.blue = fade_lvl;
            slf_pkg::MODE_CONNECTED:  want.green = slf_pkg::LEVEL_MAX;
            slf_pkg::MODE_ERROR:      want.red = fade_lvl;
            slf_pkg::MODE_CHECK:      begin
                want.red  = fade_lvl;
                want.blue = fade_lvl;
            end
            slf_pkg::MODE_UPDATE:     begin
                want.red   = fade_lvl;
                want.green = fade_lvl;
                want.blue  = fade_lvl;
            end
            default: ;
        endcase
        pending_rgb.push_back(want);
    endfunction

    // Result checker, receiver stalls and watchdog.
    always @(posedge i_clk) begin : rgb_check
        t_rgb want;
        if (i_rst_n && rgb_ch.valid && rgb_ch.ready) begin
            if (pending_rgb.size() == 0) begin
                $error("result with nothing expected: r=%0d g=%0d b=%0d",
                       rgb_ch.red, rgb_ch.green, rgb_ch.blue);
                errors++;
            end else begin
                want = pending_rgb.pop_front();
                rgb_checked++;
                if (rgb_ch.red !== want.red) begin
                    $error("red: expected %0d, got %0d", want.red, rgb_ch.red);
                    errors++;
                end
                if (rgb_ch.green !== want.green) begin
                    $error("green: expected %0d, got %0d", want.green, rgb_ch.green);
                    errors++;
                end
                if (rgb_ch.blue !== want.blue) begin
                    $error("blue: expected %0d, got %0d", want.blue, rgb_ch.blue);
                    errors++;
                end
            end
        end
        if (stall_left > 0) begin
            rgb_ch.ready <= 1'b0;
            stall_left--;
        end else begin
            rgb_ch.ready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
        end
        if ((item_ch.valid && item_ch.ready) || (rgb_ch.valid && rgb_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_item(input slf_pkg::t_mode mode, input logic [slf_pkg::NOW_W-1:0] now,
                             input logic safe);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.mode      <= mode;
        item_ch.now_ms    <= now;
        item_ch.safe_mode <= safe;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        predict_rgb(mode, now, safe);
        items_sent++;
        if (safe) safe_sent++;
    endtask

    // Hold the item channel idle until every result is back, then let the pipe settle.
    task automatic drain_results();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_rgb.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Leaves valid high; the caller drops it with end_writes.
    task automatic write_reg(input logic [slf_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [slf_pkg::CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= addr;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (addr)
            slf_pkg::REG_STEP_INTERVAL: cfg_interval = data;
            slf_pkg::REG_NORMAL_STEP:   cfg_normal   = data[slf_pkg::LEVEL_W-1:0];
            slf_pkg::REG_FAST_STEP:     cfg_fast     = data[slf_pkg::LEVEL_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic end_writes();
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [slf_pkg::CFG_DATA_W-1:0] interval,
                                input logic [slf_pkg::CFG_DATA_W-1:0] normal,
                                input logic [slf_pkg::CFG_DATA_W-1:0] fast);
        write_reg(slf_pkg::REG_STEP_INTERVAL, interval);
        write_reg(slf_pkg::REG_NORMAL_STEP, normal);
        write_reg(slf_pkg::REG_FAST_STEP, fast);
        end_writes();
    endtask

    // Reset registers: mode changes, step timing, time wrap, safe mode, every color.
    task automatic test_reset_defaults();
        send_item(slf_pkg::MODE_SYNC, 32'd0, 1'b1);
        send_item(slf_pkg::MODE_SYNC, 32'd0, 1'b0);
        send_item(slf_pkg::MODE_SYNC, 32'd9, 1'b0);
        send_item(slf_pkg::MODE_SYNC, 32'd10, 1'b0);
        send_item(slf_pkg::MODE_AP, 32'd1000, 1'b1);
        send_item(slf_pkg::MODE_SYNC, 32'd25, 1'b0);
        send_item(slf_pkg::MODE_AP, 32'd30, 1'b0);
        send_item(slf_pkg::MODE_CONNECTED, 32'hFFFF_FFFF, 1'b0);
        send_item(slf_pkg::MODE_CONNECTING, 32'hFFFF_FFFA, 1'b0);
        send_item(slf_pkg::MODE_CONNECTING, 32'd4, 1'b0);
        send_item(slf_pkg::MODE_ERROR, 32'd4, 1'b0);
        send_item(slf_pkg::MODE_ERROR, 32'd20, 1'b0);
        send_item(slf_pkg::MODE_CHECK, 32'd100, 1'b0);
        send_item(slf_pkg::MODE_CHECK, 32'd200, 1'b0);
        send_item(slf_pkg::MODE_UPDATE, 32'd300, 1'b0);
        send_item(slf_pkg::MODE_UPDATE, 32'd310, 1'b0);
        send_item(slf_pkg::MODE_OFF, 32'h8000_0000, 1'b0);
        send_item(slf_pkg::MODE_OFF, 32'hFFFF_FFFF, 1'b1);
        drain_results();
    endtask

    // Zero interval with full steps: clamp at both ends on every call.
    task automatic test_full_steps();
        program_regs(16'd0, 16'd255, 16'd255);
        send_item(slf_pkg::MODE_ERROR, 32'd0, 1'b0);
        send_item(slf_pkg::MODE_ERROR, 32'd0, 1'b0);
        send_item(slf_pkg::MODE_ERROR, 32'd1, 1'b0);
        send_item(slf_pkg::MODE_SYNC, 32'd1, 1'b0);
        send_item(slf_pkg::MODE_SYNC, 32'd1, 1'b0);
        send_item(slf_pkg::MODE_UPDATE, 32'hFFFF_FFFF, 1'b0);
        drain_results();
    endtask

    // Zero steps: the level never moves; upper data bits must be dropped.
    task automatic test_zero_steps();
        program_regs(16'd0, 16'hFF00, 16'h0000);
        write_reg(REG_SPARE, 16'hFFFF);
        end_writes();
        send_item(slf_pkg::MODE_UPDATE, 32'd5, 1'b0);
        send_item(slf_pkg::MODE_UPDATE, 32'd6, 1'b0);
        send_item(slf_pkg::MODE_SYNC, 32'd7, 1'b0);
        send_item(slf_pkg::MODE_SYNC, 32'd7, 1'b0);
        drain_results();
    endtask

    // Mostly runs of one mode with time moving around the interval, plus noise.
    task automatic test_random_traffic(input int count, input logic [slf_pkg::NOW_W-1:0] start_ms,
                                       input bit pause_midway);
        slf_pkg::t_mode            mode;
        logic [slf_pkg::NOW_W-1:0] now;
        int                        run_left;
        int                        roll;
        int                        span;
        mode     = slf_pkg::MODE_SYNC;
        now      = start_ms;
        run_left = 0;
        span     = int'(cfg_interval);
        for (int n = 0; n < count; n++) begin
            if (pause_midway && n == count / 2) drain_results();
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                send_item(slf_pkg::t_mode'($urandom_range(0, 7)), $urandom, 1'b1);
            end else if (roll < 16) begin
                send_item(slf_pkg::t_mode'($urandom_range(0, 7)), $urandom, 1'b0);
            end else begin
                if (run_left == 0) begin
                    mode     = slf_pkg::t_mode'($urandom_range(0, 7));
                    run_left = $urandom_range(1, 40);
                end
                run_left--;
                roll = $urandom_range(0, 99);
                if (roll < 20 && span > 0) now += $urandom_range(0, span - 1);
                else if (roll < 97) now += $urandom_range(span, 2 * span + 1);
                else now += $urandom;
                send_item(mode, now, 1'b0);
            end
        end
        drain_results();
    endtask

    initial begin
        i_rst_n           = 1'b0;
        item_ch.valid     = 1'b0;
        item_ch.mode      = '0;
        item_ch.now_ms    = '0;
        item_ch.safe_mode = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.addr       = '0;
        cfg_ch.data       = '0;
        cfg_interval      = slf_pkg::RST_STEP_INTERVAL;
        cfg_normal        = slf_pkg::RST_NORMAL_STEP;
        cfg_fast          = slf_pkg::RST_FAST_STEP;
        fade_lvl          = slf_pkg::LEVEL_MIN;
        fade_up           = 1'b1;
        last_step_ms      = '0;
        last_mode         = slf_pkg::NO_MODE;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_full_steps();
        test_zero_steps();

        program_regs(16'd1, 16'd1, 16'd1);
        test_random_traffic(RUN_ITEMS, 32'hFFFF_0000, 1'b0);
        program_regs(16'd65535, 16'd254, 16'd255);
        test_random_traffic(RUN_ITEMS, $urandom, 1'b0);
        program_regs(slf_pkg::RST_STEP_INTERVAL, 16'(slf_pkg::RST_NORMAL_STEP),
                     16'(slf_pkg::RST_FAST_STEP));
        test_random_traffic(RUN_ITEMS, 32'd0, 1'b1);
        calm = 1'b1;
        program_regs(16'd3, 16'd128, 16'd200);
        test_random_traffic(RUN_ITEMS, $urandom, 1'b0);
        calm = 1'b0;
        program_regs(16'($urandom_range(1, 300)), 16'($urandom_range(1, 255)),
                     16'($urandom_range(1, 255)));
        test_random_traffic(RUN_ITEMS, $urandom, 1'b0);

        $display("tb: %0d items sent (%0d in safe mode), %0d color results checked",
                 items_sent, safe_sent, rgb_checked);
        $display("tb: %0d register writes, zero, unit, default and full-scale steps and intervals",
                 reg_writes);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
